// ----- sv/bafe_pkg.sv -----
// ----------------------------------------------------------------------------
// bafe_pkg
// Shared widths, command codes and the decoded operation type of the
// bit array field engine.
// ----------------------------------------------------------------------------
package bafe_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 11;
	localparam int FW_W   = 6;
	localparam int WIU_W  = 7;
	localparam int WIDX_W = IDX_W - 5;
	localparam int OFS_W  = 5;

	localparam int QUEUE_DEPTH = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SET_BIT     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR_BIT   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TOGGLE_BIT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE_BIT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_FIELD  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE_FIELD = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SET_ALL     = 3'd7;

	// register index, taken from paddr[2]
	localparam logic REG_WORDS_IN_USE = 1'b0;
	localparam logic [WIU_W-1:0] WORDS_IN_USE_RESET = 7'd64;

	// operation classes handed from front to back
	typedef logic [2:0] kind_t;
	localparam kind_t K_IMM   = 3'd0;
	localparam kind_t K_SWEEP = 3'd1;
	localparam kind_t K_BIT   = 3'd2;
	localparam kind_t K_READ  = 3'd3;
	localparam kind_t K_WRITE = 3'd4;

	typedef logic [1:0] bop_t;
	localparam bop_t BOP_SET = 2'd0;
	localparam bop_t BOP_CLR = 2'd1;
	localparam bop_t BOP_TGL = 2'd2;

	typedef struct packed {
		kind_t              kind;
		bop_t               bop;
		logic               stat;
		logic               fill;
		logic [WIDX_W-1:0]  widx;
		logic [OFS_W-1:0]   ofs;
		logic               need_hi;
		logic [WORD_W-1:0]  mask;
		logic [WORD_W-1:0]  val;
		logic [WIU_W-1:0]   used;
	} op_t;

endpackage

// ----- sv/bafe_if.sv -----
// ----------------------------------------------------------------------------
// bafe channel interfaces
// Command and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bafe_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [bafe_pkg::CMD_W-1:0]    command;
	logic [bafe_pkg::IDX_W-1:0]    bit_index;
	logic [bafe_pkg::FW_W-1:0]     field_width;
	logic [bafe_pkg::WORD_W-1:0]   write_value;

	modport source (output valid, output command, output bit_index, output field_width,
		output write_value, input ready);
	modport sink (input valid, input command, input bit_index, input field_width,
		input write_value, output ready);
endinterface

interface bafe_res_if;
	logic                          valid;
	logic                          ready;
	logic [bafe_pkg::WORD_W-1:0]   read_data;
	logic                          status;

	modport source (output valid, output read_data, output status, input ready);
	modport sink (input valid, input read_data, input status, output ready);
endinterface

// ----- sv/bafe_ram.sv -----
// ----------------------------------------------------------------------------
// bafe_ram
// Generic RAM, one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bafe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
	output logic [WIDTH-1:0]                          rdata0,
	output logic [WIDTH-1:0]                          rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata0_q;
	logic [WIDTH-1:0] rdata1_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0_q <= mem[raddr0];
		rdata1_q <= mem[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

// ----- sv/bafe_front.sv -----
// ----------------------------------------------------------------------------
// bafe_front
// Takes command items and classifies them into decoded operations: range
// check, word index and offset, field mask, bit operation.
// ----------------------------------------------------------------------------
module bafe_front (
	bafe_cmd_if.sink                     cmd,
	input  logic [bafe_pkg::WIU_W-1:0]   used_words,
	input  logic                         init_busy,
	input  logic                         q_full,
	output logic                         push,
	output bafe_pkg::op_t                push_op
);

	logic [bafe_pkg::IDX_W:0]    idx_ext;
	logic [bafe_pkg::IDX_W:0]    limit_bits;
	logic                        in_range;
	logic [bafe_pkg::WIU_W-1:0]  next_word;
	logic [bafe_pkg::WORD_W:0]   mask_wide;
	logic                        width_ok;
	logic                        val_nz;

	assign cmd.ready = !q_full && !init_busy;
	assign push      = cmd.valid && cmd.ready;

	assign idx_ext    = {1'b0, cmd.bit_index};
	assign limit_bits = {used_words, 5'b0};
	assign in_range   = idx_ext < limit_bits;
	assign next_word  = {1'b0, cmd.bit_index[bafe_pkg::IDX_W-1:5]} + 7'd1;
	assign width_ok   = (cmd.field_width != '0) && (cmd.field_width <= 6'd32);
	assign mask_wide  = (33'd1 << cmd.field_width) - 33'd1;
	assign val_nz     = cmd.write_value != '0;

	always_comb begin
		push_op         = '0;
		push_op.widx    = cmd.bit_index[bafe_pkg::IDX_W-1:5];
		push_op.ofs     = cmd.bit_index[4:0];
		push_op.need_hi = (cmd.bit_index[4:0] != '0) && (next_word < used_words);
		push_op.mask    = width_ok ? mask_wide[bafe_pkg::WORD_W-1:0] : '0;
		push_op.val     = cmd.write_value;
		push_op.used    = used_words;
		push_op.fill    = cmd.command == bafe_pkg::CMD_SET_ALL;
		push_op.kind    = bafe_pkg::K_IMM;
		push_op.bop     = bafe_pkg::BOP_SET;
		priority if (cmd.command == bafe_pkg::CMD_CLEAR_ALL ||
				cmd.command == bafe_pkg::CMD_SET_ALL) begin
			// an empty store has nothing to sweep
			push_op.kind = (used_words == '0) ? bafe_pkg::K_IMM : bafe_pkg::K_SWEEP;
		end else if (!in_range) begin
			push_op.stat = 1'b1;
		end else begin
			unique case (cmd.command)
				bafe_pkg::CMD_SET_BIT: begin
					push_op.kind = bafe_pkg::K_BIT;
					push_op.bop  = bafe_pkg::BOP_SET;
				end
				bafe_pkg::CMD_CLEAR_BIT: begin
					push_op.kind = bafe_pkg::K_BIT;
					push_op.bop  = bafe_pkg::BOP_CLR;
				end
				bafe_pkg::CMD_TOGGLE_BIT: begin
					push_op.kind = bafe_pkg::K_BIT;
					push_op.bop  = bafe_pkg::BOP_TGL;
				end
				bafe_pkg::CMD_WRITE_BIT: begin
					push_op.kind = bafe_pkg::K_BIT;
					push_op.bop  = val_nz ? bafe_pkg::BOP_SET : bafe_pkg::BOP_CLR;
				end
				bafe_pkg::CMD_READ_FIELD: begin
					push_op.kind = bafe_pkg::K_READ;
				end
				bafe_pkg::CMD_WRITE_FIELD: begin
					// one-bit field write behaves as write bit
					if (cmd.field_width == 6'd1) begin
						push_op.kind = bafe_pkg::K_BIT;
						push_op.bop  = val_nz ? bafe_pkg::BOP_SET : bafe_pkg::BOP_CLR;
					end else begin
						push_op.kind = bafe_pkg::K_WRITE;
					end
				end
				default: begin
					push_op.kind = bafe_pkg::K_IMM;
				end
			endcase
		end
	end

endmodule

// ----- sv/bafe_queue.sv -----
// ----------------------------------------------------------------------------
// bafe_queue
// Short queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module bafe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bafe_pkg::op_t  push_op,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output bafe_pkg::op_t  head
);

	localparam int PW = (bafe_pkg::QUEUE_DEPTH > 1) ? $clog2(bafe_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(bafe_pkg::QUEUE_DEPTH + 1);

	bafe_pkg::op_t   entries_q [bafe_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = count_q == CW'(bafe_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(bafe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(bafe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/bafe_back.sv -----
// ----------------------------------------------------------------------------
// bafe_back
// Executes decoded operations on the word store: read of one or two words,
// masked update, write back, and word sweeps for clear/set all and reset.
// ----------------------------------------------------------------------------
module bafe_back #(
	parameter int MAX_WORDS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bafe_pkg::op_t  q_op,
	output logic           pop,
	output logic           init_busy,
	bafe_res_if.source     res
);

	localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_W = ($clog2(MAX_WORDS + 1) > bafe_pkg::WIU_W) ?
		$clog2(MAX_WORDS + 1) : bafe_pkg::WIU_W;
	localparam logic [CNT_W-1:0] INIT_LAST = CNT_W'(MAX_WORDS - 1);

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_WRHI  = 3'd3;
	localparam logic [2:0] ST_SWEEP = 3'd4;

	logic [2:0]                   state_q, state_d;
	logic [CNT_W-1:0]             cnt_q, cnt_d;
	bafe_pkg::op_t                op_q;
	logic [bafe_pkg::WORD_W-1:0]  hi_q;
	logic                         res_valid_q;
	logic [bafe_pkg::WORD_W-1:0]  res_data_q;
	logic                         res_stat_q;

	logic                         we;
	logic [AW-1:0]                waddr;
	logic [bafe_pkg::WORD_W-1:0]  wdata;
	logic [AW-1:0]                raddr0, raddr1;
	logic [bafe_pkg::WORD_W-1:0]  rd0, rd1;

	logic                         out_free;
	logic                         done;
	logic [bafe_pkg::WORD_W-1:0]  done_data;
	logic                         done_stat;
	logic [2*bafe_pkg::WORD_W-1:0] word64, m64, v64, new64, field64;
	logic [bafe_pkg::WORD_W-1:0]  read_val, bit_m, bit_new;
	logic [bafe_pkg::WIU_W-1:0]   hi_word;
	logic                         sweep_last;

	bafe_ram #(
		.WIDTH (bafe_pkg::WORD_W),
		.DEPTH (MAX_WORDS)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	assign raddr0 = AW'(q_op.widx);
	assign raddr1 = AW'({1'b0, q_op.widx} + 7'd1);
	assign hi_word = {1'b0, op_q.widx} + 7'd1;

	assign out_free  = !res_valid_q || res.ready;
	assign pop       = (state_q == ST_IDLE) && q_valid && out_free;
	assign init_busy = state_q == ST_INIT;

	// two adjacent words, upper one zero past the end of the store in use
	assign word64   = {op_q.need_hi ? rd1 : '0, rd0};
	assign field64  = word64 >> op_q.ofs;
	assign read_val = field64[bafe_pkg::WORD_W-1:0] & op_q.mask;
	assign bit_m    = 32'd1 << op_q.ofs;
	assign m64      = {32'b0, op_q.mask} << op_q.ofs;
	assign v64      = {32'b0, op_q.val & op_q.mask} << op_q.ofs;
	assign new64    = (word64 & ~m64) | v64;
	assign sweep_last = cnt_q == (CNT_W'(op_q.used) - CNT_W'(1));

	always_comb begin
		unique case (op_q.bop)
			bafe_pkg::BOP_SET: bit_new = rd0 | bit_m;
			bafe_pkg::BOP_CLR: bit_new = rd0 & ~bit_m;
			bafe_pkg::BOP_TGL: bit_new = rd0 ^ bit_m;
			default:           bit_new = rd0;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		we        = 1'b0;
		waddr     = AW'(op_q.widx);
		wdata     = new64[bafe_pkg::WORD_W-1:0];
		done      = 1'b0;
		done_data = '0;
		done_stat = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				// clearing pass over the whole store after reset
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = '0;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == INIT_LAST) begin
					cnt_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pop) begin
					unique case (q_op.kind)
						bafe_pkg::K_IMM: begin
							done      = 1'b1;
							done_stat = q_op.stat;
						end
						bafe_pkg::K_SWEEP: begin
							cnt_d   = '0;
							state_d = ST_SWEEP;
						end
						default: state_d = ST_EXEC;
					endcase
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (op_q.kind)
					bafe_pkg::K_BIT: begin
						we    = 1'b1;
						wdata = bit_new;
						done  = 1'b1;
					end
					bafe_pkg::K_READ: begin
						done      = 1'b1;
						done_data = read_val;
					end
					bafe_pkg::K_WRITE: begin
						we = 1'b1;
						if (op_q.need_hi) begin
							state_d = ST_WRHI;
						end else begin
							done = 1'b1;
						end
					end
					default: done = 1'b1;
				endcase
			end
			ST_WRHI: begin
				we      = 1'b1;
				waddr   = AW'(hi_word);
				wdata   = hi_q;
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = {bafe_pkg::WORD_W{op_q.fill}};
				cnt_d = cnt_q + 1'b1;
				if (sweep_last) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (done) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_op;
		end
		if (state_q == ST_EXEC) begin
			hi_q <= new64[2*bafe_pkg::WORD_W-1:bafe_pkg::WORD_W];
		end
		if (done) begin
			res_data_q <= done_data;
			res_stat_q <= done_stat;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.read_data = res_data_q;
	assign res.status    = res_stat_q;

endmodule

// ----- sv/bit_array_field_engine_core.sv -----
// ----------------------------------------------------------------------------
// bit_array_field_engine_core
// Bit-addressable store of 32-bit words with bit and field commands.
// ----------------------------------------------------------------------------
// cmd carries one command per transfer (valid/ready); res returns exactly one
// result per command, in order, with read_data and status.
// the APB port holds words_in_use at byte address 0; write it only while idle.
// a front stage decodes commands into a two-entry queue; the back stage owns
// the single-write, dual-read word RAM and works one operation at a time.
// an out-of-range or empty-store command goes from the queue straight to the
// result register; bit ops, field reads and field writes first pass the
// registered RAM read and the execute state, and a field write that also
// updates the next word adds the write-high state (the one write port).
// the back stage takes no new operation before the last is through;
// flagged or empty-store commands go one per cycle while the result register
// is free, and clear all or set all write one word per cycle over the words
// in use. reset: words_in_use returns to 64 and the back stage clears all
// MAX_WORDS words one per cycle, with cmd.ready low during that pass.
// a stalled receiver holds the result in the output register; the queue
// keeps taking commands until it is full.
module bit_array_field_engine_core #(
	parameter int MAX_WORDS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bafe_cmd_if.sink                      cmd,
	bafe_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int UCAP = (MAX_WORDS < 127) ? MAX_WORDS : 127;

	logic [bafe_pkg::WIU_W-1:0] wiu_q;
	logic [bafe_pkg::WIU_W-1:0] used_words;
	logic                       reg_sel;
	logic                       push, pop, q_full, q_valid, init_busy;
	bafe_pkg::op_t              push_op, q_op;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == bafe_pkg::REG_WORDS_IN_USE;
	assign prdata  = reg_sel ? {25'b0, wiu_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= bafe_pkg::WORDS_IN_USE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			wiu_q <= pwdata[bafe_pkg::WIU_W-1:0];
		end
	end

	// counts above the store size act as the full store
	assign used_words = (wiu_q > 7'(UCAP)) ? 7'(UCAP) : wiu_q;

	bafe_front u_front (
		.cmd        (cmd),
		.used_words (used_words),
		.init_busy  (init_busy),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	bafe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_op)
	);

	bafe_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.pop       (pop),
		.init_busy (init_busy),
		.res       (res)
	);

endmodule

// ----- sv/bafe_checker.sv -----
// ----------------------------------------------------------------------------
// bafe_checker
// Port-level checks of the engine: result accounting, latency, result hold
// and status/data consistency.
// ----------------------------------------------------------------------------
module bafe_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	input  logic         cmd_ready,
	input  logic         res_valid,
	input  logic         res_ready,
	input  logic [31:0]  read_data,
	input  logic         status
);

	logic       cmd_xfer, res_xfer;
	logic [2:0] pend_q;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign res_xfer = res_valid && res_ready;

	// commands taken whose result has not been transferred yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, cmd_xfer} - {2'b0, res_xfer};
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != '0)
		else $error("result without a pending command");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_xfer && pend_q == '0) |=> !res_valid)
		else $error("result in the cycle right after its command");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(read_data) && $stable(status)))
		else $error("stalled result changed");

	a_flag_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status) |-> read_data == '0)
		else $error("out-of-range result carries data");

endmodule

bind bit_array_field_engine_core bafe_checker u_bafe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.read_data (res.read_data),
	.status    (res.status)
);

// ----- tb/sv/bafe_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafe_result_checker
// Watches the command, result and register ports of the bit array field
// engine, keeps its own copy of the word store and words_in_use, predicts the
// result of every command transfer and compares results in order.
// ----------------------------------------------------------------------------
module bafe_result_checker
	import bafe_pkg::*;
#(
	parameter int MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bafe_cmd_if         cmd,
	bafe_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding,
	output int          results_checked,
	output int          flagged_results
);

	localparam logic [2:0] WORDS_IN_USE_ADDR = {REG_WORDS_IN_USE, 2'b00};

	typedef struct {
		logic [CMD_W-1:0]  command;
		logic [IDX_W-1:0]  bit_index;
		logic [WORD_W-1:0] read_data;
		logic              status;
	} outcome_t;

	logic [WORD_W-1:0] shadow_store [MAX_WORDS];
	logic [WIU_W-1:0]  words_in_use;
	outcome_t          pending_results [$];
	int                mismatch_count = 0;
	int                checked_count = 0;
	int                flagged_count = 0;
	int                pending_count = 0;

	assign mismatches      = mismatch_count;
	assign outstanding     = pending_count;
	assign results_checked = checked_count;
	assign flagged_results = flagged_count;

	task automatic report_mismatch(input string what);
		$display("[%0t] bafe checker: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic int unsigned words_active();
		return (words_in_use > MAX_WORDS) ? MAX_WORDS : int'(words_in_use);
	endfunction

	// word s in the low half, word s+1 above it, or zero past the store in use
	function automatic logic [2*WORD_W-1:0] word_pair(input int unsigned s,
			input int unsigned used);
		logic [WORD_W-1:0] hi;
		hi = '0;
		if (s + 1 < used)
			hi = shadow_store[s + 1];
		return {hi, shadow_store[s]};
	endfunction

	function automatic logic [WORD_W-1:0] field_window(input logic [IDX_W-1:0] idx,
			input int unsigned used);
		logic [2*WORD_W-1:0] pair;
		pair = word_pair(32'(idx[IDX_W-1:OFS_W]), used);
		return pair[idx[OFS_W-1:0] +: WORD_W];
	endfunction

	// bits that fall past the store in use are dropped
	function automatic void place_window(input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] value, input int unsigned used);
		logic [2*WORD_W-1:0] pair;
		int unsigned s;
		s = 32'(idx[IDX_W-1:OFS_W]);
		pair = word_pair(s, used);
		pair[idx[OFS_W-1:0] +: WORD_W] = value;
		shadow_store[s] = pair[WORD_W-1:0];
		if (s + 1 < used)
			shadow_store[s + 1] = pair[2*WORD_W-1:WORD_W];
	endfunction

	function automatic outcome_t predict_outcome(input logic [CMD_W-1:0] command,
			input logic [IDX_W-1:0] idx, input logic [FW_W-1:0] width,
			input logic [WORD_W-1:0] value);
		outcome_t o;
		int unsigned used;
		int unsigned s;
		logic [WORD_W-1:0] bit_mask;
		logic [WORD_W-1:0] field_mask;
		logic [WORD_W-1:0] merged;
		logic [CMD_W-1:0] op;
		used = words_active();
		o.command = command;
		o.bit_index = idx;
		o.read_data = '0;
		o.status = 1'b0;
		s = 32'(idx[IDX_W-1:OFS_W]);
		bit_mask = 32'h1 << idx[OFS_W-1:0];
		field_mask = (width < WORD_W) ? ((32'h1 << width) - 32'h1) : '1;
		op = command;
		// a one-bit field write behaves as a bit write
		if (op == CMD_WRITE_FIELD && width == 1)
			op = CMD_WRITE_BIT;
		if (command == CMD_CLEAR_ALL || command == CMD_SET_ALL) begin
			for (int i = 0; i < used; i++)
				shadow_store[i] = (command == CMD_SET_ALL) ? '1 : '0;
		end else if (idx >= used * WORD_W) begin
			o.status = 1'b1;
		end else begin
			case (op)
				CMD_SET_BIT:    shadow_store[s] |= bit_mask;
				CMD_CLEAR_BIT:  shadow_store[s] &= ~bit_mask;
				CMD_TOGGLE_BIT: shadow_store[s] ^= bit_mask;
				CMD_WRITE_BIT: begin
					if (value != 0)
						shadow_store[s] |= bit_mask;
					else
						shadow_store[s] &= ~bit_mask;
				end
				CMD_READ_FIELD: begin
					if (width >= 1 && width <= WORD_W)
						o.read_data = field_window(idx, used) & field_mask;
				end
				CMD_WRITE_FIELD: begin
					if (width == WORD_W) begin
						place_window(idx, value, used);
					end else if (width >= 2 && width < WORD_W) begin
						merged = (field_window(idx, used) & ~field_mask) | (value & field_mask);
						place_window(idx, merged, used);
					end
				end
				default: ;
			endcase
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORDS; i++)
				shadow_store[i] = '0;
			words_in_use = WORDS_IN_USE_RESET;
			pending_results.delete();
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == WORDS_IN_USE_ADDR)
				words_in_use = pwdata[WIU_W-1:0];
			if (psel && penable && !pwrite && pready && paddr == WORDS_IN_USE_ADDR &&
					prdata !== {{(32-WIU_W){1'b0}}, words_in_use})
				report_mismatch($sformatf("words_in_use read %h, expected %h", prdata,
					words_in_use));

			if (res.valid === 1'b1 && res.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result transfer with no command waiting (data %h status %b)",
						res.read_data, res.status));
				end else begin
					want = pending_results.pop_front();
					checked_count++;
					if (res.read_data !== want.read_data)
						report_mismatch($sformatf("cmd %0d idx %0d: read_data %h, expected %h",
							want.command, want.bit_index, res.read_data, want.read_data));
					if (res.status !== want.status)
						report_mismatch($sformatf("cmd %0d idx %0d: status %b, expected %b",
							want.command, want.bit_index, res.status, want.status));
				end
			end

			if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
				want = predict_outcome(cmd.command, cmd.bit_index, cmd.field_width,
					cmd.write_value);
				if (want.status)
					flagged_count++;
				pending_results.push_back(want);
			end
			pending_count = pending_results.size();
		end
	end

endmodule

// ----- tb/sv/tb_bit_array_field_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_array_field_engine_core
// Drives directed and random bit and field commands into the engine across
// a range of words_in_use settings, with bursty command traffic and a
// stalling result receiver; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bit_array_field_engine_core;
	import bafe_pkg::*;

	localparam int    MAX_WORDS         = 64;
	localparam int    ITEMS_PER_SETTING = 116;
	localparam int    DRAIN_CYCLES      = 2 * MAX_WORDS + 16;
	localparam longint RUN_LIMIT_NS     = 20_000_000;
	localparam logic [2:0] WORDS_IN_USE_ADDR = {REG_WORDS_IN_USE, 2'b00};

	// receiver stall patterns
	localparam int RX_ALWAYS   = 0;
	localparam int RX_MOSTLY   = 1;
	localparam int RX_RARELY   = 2;
	localparam int RX_PERIODIC = 3;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          outstanding;
	int          results_checked;
	int          flagged_results;

	int unsigned burst_left = 0;
	int unsigned commands_sent = 0;
	logic [IDX_W-1:0] last_field_idx = '0;
	logic [FW_W-1:0]  last_field_width = 6'd1;

	bafe_cmd_if cmd_if ();
	bafe_res_if res_if ();

	bit_array_field_engine_core #(
		.MAX_WORDS(MAX_WORDS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	bafe_result_checker #(
		.MAX_WORDS(MAX_WORDS)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd_if),
		.res             (res_if),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.flagged_results (flagged_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("[bit_array_field_engine_core] ERROR");
		$finish;
	end

	// result receiver: the stall pattern is drawn anew after each random stretch
	initial begin
		int unsigned mode;
		int unsigned stretch;
		int unsigned tick;
		tick = 0;
		res_if.ready = 1'b0;
		forever begin
			mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
			stretch = $urandom_range(16, 300);
			repeat (stretch) begin
				@(negedge clk);
				case (mode)
					RX_ALWAYS: res_if.ready = 1'b1;
					RX_MOSTLY: res_if.ready = ($urandom_range(0, 3) != 0);
					RX_RARELY: res_if.ready = ($urandom_range(0, 3) == 0);
					default:   res_if.ready = ((tick % 5) != 0);
				endcase
				tick++;
			end
		end
	end

	// one APB transfer; psel stays high so accesses can run back to back
	task automatic reg_access(input logic is_write, input logic [WIU_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = is_write;
		paddr = WORDS_IN_USE_ADDR;
		pwdata = ($urandom() & ~32'h7F) | 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_command(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
			input logic [FW_W-1:0] fw, input logic [WORD_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				cmd_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		cmd_if.valid = 1'b1;
		cmd_if.command = c;
		cmd_if.bit_index = idx;
		cmd_if.field_width = fw;
		cmd_if.write_value = v;
		do @(posedge clk); while (cmd_if.ready !== 1'b1);
		@(negedge clk);
		commands_sent++;
	endtask

	task automatic send_random_command(input int unsigned used);
		int unsigned span;
		int unsigned pick;
		logic [CMD_W-1:0]  c;
		logic [IDX_W-1:0]  idx;
		logic [FW_W-1:0]   fw;
		logic [WORD_W-1:0] v;
		span = used * WORD_W;

		pick = $urandom_range(0, 99);
		if (pick < 2)
			c = CMD_CLEAR_ALL;
		else if (pick < 4)
			c = CMD_SET_ALL;
		else if (pick < 34)
			c = CMD_READ_FIELD;
		else if (pick < 64)
			c = CMD_WRITE_FIELD;
		else begin
			case ($urandom_range(0, 3))
				0:       c = CMD_SET_BIT;
				1:       c = CMD_CLEAR_BIT;
				2:       c = CMD_TOGGLE_BIT;
				default: c = CMD_WRITE_BIT;
			endcase
		end

		pick = $urandom_range(0, 9);
		if (span == 0 || pick == 0)
			idx = IDX_W'($urandom_range(0, 2047));
		else if (pick == 1)
			idx = IDX_W'(span - $urandom_range(1, WORD_W));  // tail of the store, fields cut off
		else if (pick == 2)
			idx = IDX_W'($urandom_range(0, used - 1) * WORD_W + $urandom_range(20, 31));
		else
			idx = IDX_W'($urandom_range(0, span - 1));

		pick = $urandom_range(0, 19);
		if (pick == 0)
			fw = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
		else if (pick == 1)
			fw = 6'd32;
		else if (pick == 2)
			fw = 6'd1;
		else
			fw = FW_W'($urandom_range(2, 31));

		// read back a recent field write now and then
		if (c == CMD_READ_FIELD && $urandom_range(0, 3) == 0) begin
			idx = last_field_idx;
			fw = last_field_width;
		end
		if (c == CMD_WRITE_FIELD) begin
			last_field_idx = idx;
			last_field_width = fw;
		end

		pick = $urandom_range(0, 9);
		if (pick == 0)
			v = '0;
		else if (pick == 1)
			v = '1;
		else
			v = $urandom();
		send_command(c, idx, fw, v);
	endtask

	task automatic wait_until_drained();
		cmd_if.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int unsigned settings [12];
		int unsigned used;
		settings = '{1, 0, 2, 127, 33, 64, 0, 65, 17, 1, 100, 0};
		settings[11] = $urandom_range(1, MAX_WORDS);

		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.command = CMD_SET_BIT;
		cmd_if.bit_index = '0;
		cmd_if.field_width = '0;
		cmd_if.write_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		reg_access(1'b0, '0);
		psel = 1'b0;
		penable = 1'b0;

		// directed pass at the reset setting
		send_command(CMD_READ_FIELD, 11'd0, 6'd32, 32'h0);
		send_command(CMD_SET_ALL, 11'd0, 6'd0, 32'h0);
		send_command(CMD_READ_FIELD, 11'd2016, 6'd32, 32'h0);
		send_command(CMD_READ_FIELD, 11'd2040, 6'd32, 32'h0);
		send_command(CMD_CLEAR_BIT, 11'd0, 6'd0, 32'h0);
		send_command(CMD_CLEAR_BIT, 11'd2047, 6'd0, 32'h0);
		send_command(CMD_TOGGLE_BIT, 11'd31, 6'd0, 32'h0);
		send_command(CMD_TOGGLE_BIT, 11'd32, 6'd0, 32'h0);
		send_command(CMD_READ_FIELD, 11'd30, 6'd4, 32'h0);
		send_command(CMD_WRITE_BIT, 11'd5, 6'd0, 32'h0);
		send_command(CMD_WRITE_BIT, 11'd5, 6'd0, 32'h8000_0000);
		send_command(CMD_WRITE_FIELD, 11'd17, 6'd32, 32'hA5A5_5A5A);
		send_command(CMD_READ_FIELD, 11'd17, 6'd32, 32'h0);
		send_command(CMD_WRITE_FIELD, 11'd64, 6'd32, 32'h0);
		send_command(CMD_WRITE_FIELD, 11'd2030, 6'd32, 32'h1234_5678);
		send_command(CMD_READ_FIELD, 11'd2016, 6'd32, 32'h0);
		send_command(CMD_WRITE_FIELD, 11'd100, 6'd1, 32'h2);
		send_command(CMD_WRITE_FIELD, 11'd101, 6'd1, 32'h0);
		send_command(CMD_WRITE_FIELD, 11'd10, 6'd0, 32'hFFFF_FFFF);
		send_command(CMD_WRITE_FIELD, 11'd10, 6'd63, 32'hFFFF_FFFF);
		send_command(CMD_READ_FIELD, 11'd3, 6'd0, 32'h0);
		send_command(CMD_READ_FIELD, 11'd3, 6'd33, 32'h0);
		send_command(CMD_WRITE_FIELD, 11'd33, 6'd31, 32'hFFFF_FFFF);
		send_command(CMD_READ_FIELD, 11'd33, 6'd31, 32'h0);
		send_command(CMD_CLEAR_ALL, 11'd2047, 6'd63, 32'hFFFF_FFFF);
		send_command(CMD_READ_FIELD, 11'd2047, 6'd1, 32'h0);

		foreach (settings[p]) begin
			wait_until_drained();
			reg_access(1'b1, WIU_W'(settings[p]));
			reg_access(1'b0, '0);
			psel = 1'b0;
			penable = 1'b0;
			used = (settings[p] > MAX_WORDS) ? MAX_WORDS : settings[p];
			repeat (ITEMS_PER_SETTING)
				send_random_command(used);
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("ran %0d commands over %0d words_in_use settings, empty and oversized included",
			commands_sent, $size(settings) + 1);
		$display("%0d results checked, %0d flagged as beyond the store in use",
			results_checked, flagged_results);
		if (mismatches == 0)
			$display("[bit_array_field_engine_core] OK");
		else
			$display("[bit_array_field_engine_core] ERROR");
		$finish;
	end

endmodule
